// File: sv/i2cbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared types and constants for the bit-level I2C master.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

   localparam int unsigned ACT_W   = 3;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned BIT_CNT_W = 3;

   localparam logic [BYTE_W-1:0]    ACK_TIMEOUT_RESET = 8'd250;
   localparam logic [BIT_CNT_W-1:0] LAST_BIT          = 3'd7;

   // Command codes carried on the action field
   typedef enum logic [ACT_W-1:0] {
      ACT_TICK  = 3'd0,
      ACT_START = 3'd1,
      ACT_STOP  = 3'd2,
      ACT_WRITE = 3'd3,
      ACT_READ  = 3'd4,
      ACT_ACK   = 3'd5,
      ACT_WAIT  = 3'd6
   } action_type;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_START_B,
      PH_START_C,
      PH_STOP_B,
      PH_STOP_C,
      PH_ACK_B,
      PH_ACK_C,
      PH_WR_HIGH,
      PH_WR_LOW,
      PH_RD_HIGH,
      PH_RD_LOW,
      PH_WA_POLL
   } phase_type;

   typedef struct packed {
      logic              scl;
      logic              sda;
      logic              busy;
      logic              done;
      logic [BYTE_W-1:0] read_data;
      logic              ack_missing;
   } result_type;

endpackage

// File: sv/i2cbm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_seq
// Bus phase sequencer: holds the SCL/SDA state and advances it by one tick
// for every transaction that moves into the result register.
// ----------------------------------------------------------------------------
module i2cbm_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [i2cbm_pkg::ACT_W-1:0]   action,
   input  logic [i2cbm_pkg::BYTE_W-1:0]  write_data,
   input  logic                          send_nack,
   input  logic                          sda_in,
   input  logic [i2cbm_pkg::BYTE_W-1:0]  ack_timeout,
   output i2cbm_pkg::result_type         result
);
   import i2cbm_pkg::*;

   phase_type            phase_ff,     phase_in;
   logic [BIT_CNT_W-1:0] bit_count_ff, bit_count_in;
   logic [BYTE_W-1:0]    shift_ff,     shift_in;
   logic [BYTE_W-1:0]    poll_ff,      poll_in;
   logic [BYTE_W-1:0]    read_hold_ff, read_hold_in;
   logic                 scl_ff,       scl_in;
   logic                 sda_ff,       sda_in_lvl;
   logic                 nack_ff,      nack_in;
   logic                 done;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_count_ff <= '0;
         shift_ff     <= '0;
         poll_ff      <= '0;
         read_hold_ff <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         nack_ff      <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
         poll_ff      <= poll_in;
         read_hold_ff <= read_hold_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in_lvl;
         nack_ff      <= nack_in;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      poll_in      = poll_ff;
      read_hold_in = read_hold_ff;
      scl_in       = scl_ff;
      sda_in_lvl   = sda_ff;
      nack_in      = nack_ff;
      done         = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            unique case (action)
               ACT_START: begin
                  scl_in = 1'b1; sda_in_lvl = 1'b1; phase_in = PH_START_B;
               end
               ACT_STOP: begin
                  scl_in = 1'b0; sda_in_lvl = 1'b0; phase_in = PH_STOP_B;
               end
               ACT_WRITE: begin
                  shift_in = write_data; bit_count_in = '0;
                  scl_in = 1'b0; sda_in_lvl = write_data[BYTE_W-1];
                  phase_in = PH_WR_HIGH;
               end
               ACT_READ: begin
                  shift_in = '0; bit_count_in = '0;
                  scl_in = 1'b0; sda_in_lvl = 1'b1; phase_in = PH_RD_HIGH;
               end
               ACT_ACK: begin
                  scl_in = 1'b0; sda_in_lvl = send_nack; phase_in = PH_ACK_B;
               end
               ACT_WAIT: begin
                  poll_in = '0; nack_in = 1'b0;
                  scl_in = 1'b1; sda_in_lvl = 1'b1; phase_in = PH_WA_POLL;
               end
               default: ;
            endcase
         end
         PH_START_B: begin
            sda_in_lvl = 1'b0; phase_in = PH_START_C;
         end
         PH_START_C: begin
            scl_in = 1'b0; phase_in = PH_IDLE; done = 1'b1;
         end
         PH_STOP_B: begin
            scl_in = 1'b1; phase_in = PH_STOP_C;
         end
         PH_STOP_C: begin
            sda_in_lvl = 1'b1; phase_in = PH_IDLE; done = 1'b1;
         end
         PH_ACK_B: begin
            scl_in = 1'b1; phase_in = PH_ACK_C;
         end
         PH_ACK_C: begin
            scl_in = 1'b0; phase_in = PH_IDLE; done = 1'b1;
         end
         PH_WR_HIGH: begin
            scl_in   = 1'b1;
            shift_in = {shift_ff[BYTE_W-2:0], 1'b0};
            phase_in = PH_WR_LOW;
         end
         PH_WR_LOW: begin
            scl_in = 1'b0;
            if (bit_count_ff == LAST_BIT) begin
               phase_in = PH_IDLE; done = 1'b1;
            end else begin
               bit_count_in = bit_count_ff + 1'b1;
               sda_in_lvl   = shift_ff[BYTE_W-1];
               phase_in     = PH_WR_HIGH;
            end
         end
         PH_RD_HIGH: begin
            scl_in   = 1'b1;
            shift_in = {shift_ff[BYTE_W-2:0], sda_in};
            phase_in = PH_RD_LOW;
         end
         PH_RD_LOW: begin
            scl_in = 1'b0;
            if (bit_count_ff == LAST_BIT) begin
               read_hold_in = shift_ff; phase_in = PH_IDLE; done = 1'b1;
            end else begin
               bit_count_in = bit_count_ff + 1'b1;
               phase_in     = PH_RD_HIGH;
            end
         end
         PH_WA_POLL: begin
            if (!sda_in) begin
               scl_in = 1'b0; nack_in = 1'b0; phase_in = PH_IDLE; done = 1'b1;
            end else if (poll_ff >= ack_timeout) begin
               // timed out: flag it and drive the stop sequence
               nack_in = 1'b1; scl_in = 1'b0; sda_in_lvl = 1'b0;
               phase_in = PH_STOP_B;
            end else begin
               poll_in = poll_ff + 1'b1;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_comb begin
      result.scl         = scl_in;
      result.sda         = sda_in_lvl;
      result.busy        = (phase_in != PH_IDLE);
      result.done        = done;
      result.read_data   = read_hold_in;
      result.ack_missing = nack_in;
   end

endmodule

// File: sv/i2c_bit_level_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bit_level_master
// Tick-driven I2C master: one request per bus tick, one response per request.
// ----------------------------------------------------------------------------
// Each request is one bus timing tick carrying the sampled SDA level and, when
// the master is idle, an optional command (start, stop, write byte, read byte,
// send ack/nack, wait ack). One request is taken every clock while the response
// is not stalled; its response is valid once the transaction has moved from
// the request register into the result register, the phase sequencer
// advancing by one tick as it does. Only a stalled response holds the input.
// Commands that arrive while busy are ignored. The ack timeout register may be
// written through the csr port while no transaction is in flight; it resets
// to 250.
module i2c_bit_level_master (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [i2cbm_pkg::ACT_W-1:0]   req_action,
   input  logic [i2cbm_pkg::BYTE_W-1:0]  req_write_data,
   input  logic                          req_send_nack,
   input  logic                          req_sda_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_scl_out,
   output logic                          rsp_sda_out,
   output logic                          rsp_busy_res,
   output logic                          rsp_done_res,
   output logic [i2cbm_pkg::BYTE_W-1:0]  rsp_read_data,
   output logic                          rsp_ack_missing,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [i2cbm_pkg::BYTE_W-1:0]  csr_data
);
   import i2cbm_pkg::*;

   logic              in_valid_ff;
   logic [ACT_W-1:0]  action_ff;
   logic [BYTE_W-1:0] wdata_ff;
   logic              nack_ff;
   logic              sda_ff;
   logic [BYTE_W-1:0] timeout_ff;
   logic              rsp_valid_ff;
   result_type        rsp_ff;
   result_type        result;
   logic              advance;
   logic              take;

   assign advance   = in_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= ACK_TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         timeout_ff <= csr_data;
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take || advance) begin
         in_valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         action_ff <= req_action;
         wdata_ff  <= req_write_data;
         nack_ff   <= req_send_nack;
         sda_ff    <= req_sda_in;
      end
   end

   i2cbm_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .action      (action_ff),
      .write_data  (wdata_ff),
      .send_nack   (nack_ff),
      .sda_in      (sda_ff),
      .ack_timeout (timeout_ff),
      .result      (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance || !rsp_stall) begin
         rsp_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_scl_out     = rsp_ff.scl;
   assign rsp_sda_out     = rsp_ff.sda;
   assign rsp_busy_res    = rsp_ff.busy;
   assign rsp_done_res    = rsp_ff.done;
   assign rsp_read_data   = rsp_ff.read_data;
   assign rsp_ack_missing = rsp_ff.ack_missing;

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done and busy reported together");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("request stalled with an empty request register");

   a_item_moves: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !(rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("transaction lost between request and result registers");

endmodule

// File: test/i2c_bit_level_master_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bit_level_master_tb
// Self-checking regression for the tick-driven I2C bit-level master.
// ----------------------------------------------------------------------------
// A bus-level tracker follows SCL/SDA, the command phase, the bit counter,
// the ack poll counter and the held read byte for every accepted tick, and
// queues the expected response. Each accepted response is checked field by
// field. Stimulus is a directed pass over every command and the timeout
// corners, then random command sequences with bus-shaped SDA samples, under
// several ack timeout settings, random idling on both sides and a long
// response hold-off.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_tb;
   import i2cbm_pkg::*;

   localparam logic [ACT_W-1:0] ACT_UNUSED  = 3'd7;
   localparam int               HOLD_CYCLES = 300;
   localparam int               CYCLE_LIMIT = 400000;
   localparam int               PHASE_TICKS = 90;
   localparam int               PRINT_CAP   = 40;

   class level_tracker;
      logic [BYTE_W-1:0]    ack_limit;
      phase_type            bus_phase;
      logic [BIT_CNT_W-1:0] bits_done;
      logic [BYTE_W-1:0]    shifter;
      logic [BYTE_W-1:0]    polls;
      logic                 scl;
      logic                 sda;
      logic                 nack;
      logic [BYTE_W-1:0]    read_byte;
      result_type           expected_levels[$];
      int                   mismatches;

      function new();
         ack_limit  = ACK_TIMEOUT_RESET;
         bus_phase  = PH_IDLE;
         bits_done  = '0;
         shifter    = '0;
         polls      = '0;
         scl        = 1'b1;
         sda        = 1'b1;
         nack       = 1'b0;
         read_byte  = '0;
         mismatches = 0;
      endfunction

      function void set_timeout(logic [BYTE_W-1:0] value);
         ack_limit = value;
      endfunction

      function bit bus_idle();
         return bus_phase == PH_IDLE;
      endfunction

      function bit in_ack_poll();
         return bus_phase == PH_WA_POLL;
      endfunction

      function int pending();
         return expected_levels.size();
      endfunction

      // Advance the bus by one tick and queue the levels it leaves behind.
      function void take_tick(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] wd,
                              logic nk, logic si);
         result_type want;
         logic       fin;
         fin = 1'b0;
         case (bus_phase)
            PH_IDLE: begin
               case (act)
                  ACT_START: begin
                     scl = 1'b1; sda = 1'b1; bus_phase = PH_START_B;
                  end
                  ACT_STOP: begin
                     sda = 1'b0; scl = 1'b0; bus_phase = PH_STOP_B;
                  end
                  ACT_WRITE: begin
                     shifter = wd; bits_done = '0;
                     scl = 1'b0; sda = wd[7]; bus_phase = PH_WR_HIGH;
                  end
                  ACT_READ: begin
                     shifter = '0; bits_done = '0;
                     scl = 1'b0; sda = 1'b1; bus_phase = PH_RD_HIGH;
                  end
                  ACT_ACK: begin
                     scl = 1'b0; sda = nk; bus_phase = PH_ACK_B;
                  end
                  ACT_WAIT: begin
                     polls = '0; nack = 1'b0;
                     scl = 1'b1; sda = 1'b1; bus_phase = PH_WA_POLL;
                  end
                  default: ;
               endcase
            end
            PH_START_B: begin
               sda = 1'b0; bus_phase = PH_START_C;
            end
            PH_START_C: begin
               scl = 1'b0; bus_phase = PH_IDLE; fin = 1'b1;
            end
            PH_STOP_B: begin
               scl = 1'b1; bus_phase = PH_STOP_C;
            end
            PH_STOP_C: begin
               sda = 1'b1; bus_phase = PH_IDLE; fin = 1'b1;
            end
            PH_ACK_B: begin
               scl = 1'b1; bus_phase = PH_ACK_C;
            end
            PH_ACK_C: begin
               scl = 1'b0; bus_phase = PH_IDLE; fin = 1'b1;
            end
            PH_WR_HIGH: begin
               scl = 1'b1; shifter = shifter << 1; bus_phase = PH_WR_LOW;
            end
            PH_WR_LOW: begin
               scl = 1'b0;
               if (bits_done == LAST_BIT) begin
                  bus_phase = PH_IDLE; fin = 1'b1;
               end else begin
                  bits_done = bits_done + 1'b1;
                  sda = shifter[7];
                  bus_phase = PH_WR_HIGH;
               end
            end
            PH_RD_HIGH: begin
               scl = 1'b1; shifter = {shifter[6:0], si}; bus_phase = PH_RD_LOW;
            end
            PH_RD_LOW: begin
               scl = 1'b0;
               if (bits_done == LAST_BIT) begin
                  read_byte = shifter; bus_phase = PH_IDLE; fin = 1'b1;
               end else begin
                  bits_done = bits_done + 1'b1;
                  bus_phase = PH_RD_HIGH;
               end
            end
            PH_WA_POLL: begin
               if (!si) begin
                  scl = 1'b0; nack = 1'b0; bus_phase = PH_IDLE; fin = 1'b1;
               end else if (polls >= ack_limit) begin
                  // no ack in time: flag it and fall into the stop sequence
                  nack = 1'b1; sda = 1'b0; scl = 1'b0; bus_phase = PH_STOP_B;
               end else begin
                  polls = polls + 1'b1;
               end
            end
            default: bus_phase = PH_IDLE;
         endcase
         want.scl         = scl;
         want.sda         = sda;
         want.busy        = (bus_phase != PH_IDLE);
         want.done        = fin;
         want.read_data   = read_byte;
         want.ack_missing = nack;
         expected_levels.push_back(want);
      endfunction

      task report(string msg);
         if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_levels(result_type got);
         result_type want;
         if (expected_levels.size() == 0) begin
            report("response with no transaction pending");
            return;
         end
         want = expected_levels.pop_front();
         if (got.scl !== want.scl)
            report($sformatf("scl_out got %0b expected %0b", got.scl, want.scl));
         if (got.sda !== want.sda)
            report($sformatf("sda_out got %0b expected %0b", got.sda, want.sda));
         if (got.busy !== want.busy)
            report($sformatf("busy_res got %0b expected %0b", got.busy, want.busy));
         if (got.done !== want.done)
            report($sformatf("done_res got %0b expected %0b", got.done, want.done));
         if (got.read_data !== want.read_data)
            report($sformatf("read_data got %02h expected %02h",
                             got.read_data, want.read_data));
         if (got.ack_missing !== want.ack_missing)
            report($sformatf("ack_missing got %0b expected %0b",
                             got.ack_missing, want.ack_missing));
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [ACT_W-1:0]    req_action;
   logic [BYTE_W-1:0]   req_write_data;
   logic                req_send_nack;
   logic                req_sda_in;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_scl_out;
   logic                rsp_sda_out;
   logic                rsp_busy_res;
   logic                rsp_done_res;
   logic [BYTE_W-1:0]   rsp_read_data;
   logic                rsp_ack_missing;
   logic                csr_valid;
   logic                csr_ready;
   logic [BYTE_W-1:0]   csr_data;

   level_tracker tracker = new();
   bit           tx_gaps;
   bit           rx_bursts;
   bit           hold_request;
   bit           ack_never;
   int           cycle_count = 0;

   i2c_bit_level_master dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_write_data  (req_write_data),
      .req_send_nack   (req_send_nack),
      .req_sda_in      (req_sda_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_scl_out     (rsp_scl_out),
      .rsp_sda_out     (rsp_sda_out),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_done_res    (rsp_done_res),
      .rsp_read_data   (rsp_read_data),
      .rsp_ack_missing (rsp_ack_missing),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("i2c_bit_level_master regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin : check_rsp
      result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.scl         = rsp_scl_out;
         got.sda         = rsp_sda_out;
         got.busy        = rsp_busy_res;
         got.done        = rsp_done_res;
         got.read_data   = rsp_read_data;
         got.ack_missing = rsp_ack_missing;
         tracker.check_levels(got);
      end
   end

   // Response side: random stall bursts, or one long hold-off on request.
   initial begin : rsp_side
      bit hold_served;
      hold_served = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_served) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_served = 1'b1;
         end else if (rx_bursts && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_tick(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] wd,
                            input logic nk, input logic si);
      req_valid      <= 1'b1;
      req_action     <= act;
      req_write_data <= wd;
      req_send_nack  <= nk;
      req_sda_in     <= si;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_tick(act, wd, nk, si);
   endtask

   task automatic idle_gap(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Tick the bus with a fixed SDA level until the command in progress ends.
   task automatic finish_command(input logic si);
      while (!tracker.bus_idle())
         send_tick(ACT_TICK, 8'($urandom), 1'($urandom), si);
   endtask

   task automatic run_command(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] wd,
                              input logic nk, input logic si);
      send_tick(act, wd, nk, si);
      finish_command(si);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [BYTE_W-1:0] value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      tracker.set_timeout(value);
   endtask

   // Issue a command on most ticks while the bus is free; otherwise mostly plain ticks,
   // with an occasional command that the busy master must drop.
   task automatic random_tick();
      logic [ACT_W-1:0] act;
      logic             si;
      if (tracker.bus_idle()) begin
         act = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                            : 3'($urandom_range(1, 6));
         if (act == ACT_WAIT)
            ack_never = ($urandom_range(0, 2) == 0);
      end else begin
         act = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : ACT_TICK;
      end
      if (tracker.in_ack_poll())
         si = ack_never ? 1'b1 : ($urandom_range(0, 3) != 0);
      else
         si = 1'($urandom);
      send_tick(act, 8'($urandom), 1'($urandom), si);
      if (tx_gaps && $urandom_range(0, 7) == 0)
         idle_gap($urandom_range(1, 10));
   endtask

   initial begin
      logic [BYTE_W-1:0] settings [5];
      settings = '{8'd3, 8'd0, 8'd255, 8'($urandom_range(0, 255)), 8'd1};
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_action     <= ACT_TICK;
      req_write_data <= '0;
      req_send_nack  <= 1'b0;
      req_sda_in     <= 1'b1;
      csr_valid      <= 1'b0;
      csr_data       <= '0;
      tx_gaps         = 1'b1;
      rx_bursts       = 1'b1;
      hold_request    = 1'b0;
      ack_never       = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed pass at the reset timeout
      run_command(ACT_START, 8'h00, 1'b0, 1'b1);
      run_command(ACT_WRITE, 8'hFF, 1'b0, 1'b0);
      run_command(ACT_WRITE, 8'h00, 1'b1, 1'b1);
      run_command(ACT_READ, 8'hA5, 1'b0, 1'b1);
      run_command(ACT_READ, 8'h5A, 1'b1, 1'b0);
      run_command(ACT_ACK, 8'h00, 1'b0, 1'b1);
      run_command(ACT_ACK, 8'hFF, 1'b1, 1'b0);
      run_command(ACT_WAIT, 8'h00, 1'b0, 1'b0);
      run_command(ACT_WAIT, 8'h00, 1'b0, 1'b1);
      // drop a command offered while a start is under way
      send_tick(ACT_START, 8'h00, 1'b0, 1'b1);
      send_tick(ACT_WRITE, 8'hFF, 1'b1, 1'b1);
      finish_command(1'b1);
      send_tick(ACT_UNUSED, 8'hFF, 1'b1, 1'b0);
      run_command(ACT_STOP, 8'h00, 1'b0, 1'b1);

      // zero timeout: the first high poll times out
      drain_results();
      write_timeout(8'd0);
      run_command(ACT_WAIT, 8'h00, 1'b0, 1'b1);
      drain_results();
      write_timeout(8'd255);
      run_command(ACT_WAIT, 8'h00, 1'b0, 1'b1);

      for (int p = 0; p < 5; p++) begin
         drain_results();
         write_timeout(settings[p]);
         tx_gaps   = (p != 4);
         rx_bursts = (p != 4);
         if (p == 1)
            hold_request = 1'b1;
         repeat (PHASE_TICKS) random_tick();
      end

      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("i2c_bit_level_master regression: pass");
      else
         $display("i2c_bit_level_master regression: fail");
      $finish;
   end

endmodule
